[hdl/fpsnr_pkg.sv]
package fpsnr_pkg;

  typedef struct packed {
    logic [7:0] ref_c0;
    logic [7:0] ref_c1;
    logic [7:0] ref_c2;
    logic [7:0] test_c0;
    logic [7:0] test_c1;
    logic [7:0] test_c2;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        frame_index;
    logic [39:0]        sse_c0;
    logic [39:0]        sse_c1;
    logic [39:0]        sse_c2;
    logic signed [15:0] psnr_c0;
    logic signed [15:0] psnr_c1;
    logic signed [15:0] psnr_c2;
    logic [2:0]         zero_error_mask;
  } out_item_t;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int SSE_W     = 40;
  localparam int LOG_FRAC  = 24;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_VALUE   = 2'd2;

  localparam logic [12:0] RST_FRAME_WIDTH  = 13'd1920;
  localparam logic [12:0] RST_FRAME_HEIGHT = 13'd1080;
  localparam logic [7:0]  RST_PEAK_VALUE   = 8'd200;

  // 10*log10(2) in Q2.30
  localparam logic [31:0] DB_PER_OCTAVE = 32'd3232284966;

  localparam logic [15:0] PSNR_MAX = 16'h7FFF;

endpackage

[hdl/fpsnr_front.sv]
module fpsnr_front #(
  parameter int MAX_DIM = 4096,
  parameter int N_W     = 26,
  parameter int REC_W   = 178
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [fpsnr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [fpsnr_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                          in_push,
  input  fpsnr_pkg::in_item_t           in_data,
  output logic                          in_full,
  output logic                          q_push,
  output logic [REC_W-1:0]              q_rec,
  input  logic                          q_full
);
  import fpsnr_pkg::*;

  localparam int DIM_W = N_W / 2;
  localparam int EXT_W = (DIM_W > CFG_W) ? DIM_W : CFG_W;
  localparam logic [EXT_W-1:0] MAX_EXT = EXT_W'(MAX_DIM);

  logic [12:0] width_r, height_r;
  logic [7:0]  peak_r;
  logic [SSE_W-1:0] sum_r [3];
  logic [SSE_W-1:0] sum_nxt [3];
  logic [N_W-1:0]   cnt_r;
  logic [15:0]      frame_r;

  logic [EXT_W-1:0] w_ext, h_ext, w_cl, h_cl;
  logic [N_W-1:0]   n;
  logic [7:0]       pk1;
  logic [15:0]      pksq;
  logic [N_W:0]     cnt_inc;
  logic             accept, frame_end;
  logic [7:0]       refv [3];
  logic [7:0]       tstv [3];

  always_comb begin
    w_ext = EXT_W'(width_r);
    h_ext = EXT_W'(height_r);
    w_cl  = (w_ext == '0) ? EXT_W'(1) : ((w_ext > MAX_EXT) ? MAX_EXT : w_ext);
    h_cl  = (h_ext == '0) ? EXT_W'(1) : ((h_ext > MAX_EXT) ? MAX_EXT : h_ext);
    n     = N_W'(w_cl[DIM_W-1:0]) * N_W'(h_cl[DIM_W-1:0]);
    pk1   = (peak_r == 8'd0) ? 8'd1 : peak_r;
    pksq  = 16'(pk1) * 16'(pk1);
  end

  assign refv[0] = in_data.ref_c0;
  assign refv[1] = in_data.ref_c1;
  assign refv[2] = in_data.ref_c2;
  assign tstv[0] = in_data.test_c0;
  assign tstv[1] = in_data.test_c1;
  assign tstv[2] = in_data.test_c2;

  // absolute difference, square, saturating accumulate
  always_comb begin
    logic [7:0]       ad;
    logic [15:0]      sq;
    logic [SSE_W:0]   s;
    for (int k = 0; k < 3; k++) begin
      ad = (refv[k] >= tstv[k]) ? (refv[k] - tstv[k]) : (tstv[k] - refv[k]);
      sq = 16'(ad) * 16'(ad);
      s  = {1'b0, sum_r[k]} + (SSE_W + 1)'(sq);
      sum_nxt[k] = s[SSE_W] ? {SSE_W{1'b1}} : s[SSE_W-1:0];
    end
  end

  assign in_full   = q_full;
  assign accept    = in_push && !q_full;
  assign cnt_inc   = (N_W + 1)'(cnt_r) + (N_W + 1)'(1);
  assign frame_end = cnt_inc >= (N_W + 1)'(n);
  assign q_push    = accept && frame_end;
  assign q_rec     = {frame_r, sum_nxt[0], sum_nxt[1], sum_nxt[2], n, pksq};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_FRAME_WIDTH;
      height_r <= RST_FRAME_HEIGHT;
      peak_r   <= RST_PEAK_VALUE;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_FRAME_WIDTH:  width_r  <= cfg_wdata;
        REG_FRAME_HEIGHT: height_r <= cfg_wdata;
        REG_PEAK_VALUE:   peak_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) sum_r[k] <= '0;
      cnt_r   <= '0;
      frame_r <= '0;
    end else if (accept) begin
      if (frame_end) begin
        for (int k = 0; k < 3; k++) sum_r[k] <= '0;
        cnt_r   <= '0;
        frame_r <= frame_r + 16'd1;
      end else begin
        for (int k = 0; k < 3; k++) sum_r[k] <= sum_nxt[k];
        cnt_r <= cnt_inc[N_W-1:0];
      end
    end
  end

endmodule

[hdl/fpsnr_queue.sv]
module fpsnr_queue #(
  parameter int W = 178
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  import fpsnr_pkg::*;

  logic [W-1:0] slot_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

[hdl/fpsnr_back.sv]
module fpsnr_back #(
  parameter int PSNR_FRAC_BITS = 8,
  parameter int N_W            = 26,
  parameter int REC_W          = 178
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [REC_W-1:0]     q_rec,
  input  logic                 q_empty,
  output logic                 q_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output fpsnr_pkg::out_item_t out_data
);
  import fpsnr_pkg::*;

  localparam int X_W = ((16 + N_W) > SSE_W) ? (16 + N_W) : SSE_W;
  localparam int E_W = $clog2(X_W);
  localparam int L_W = E_W + LOG_FRAC;
  localparam int P_W = L_W + 32;
  localparam int SH  = LOG_FRAC + 30 - PSNR_FRAC_BITS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_NUM  = 4'd1;
  localparam logic [3:0] S_LOAD = 4'd2;
  localparam logic [3:0] S_NORM = 4'd3;
  localparam logic [3:0] S_SQ   = 4'd4;
  localparam logic [3:0] S_DEC  = 4'd5;
  localparam logic [3:0] S_DIFF = 4'd6;
  localparam logic [3:0] S_PMUL = 4'd7;
  localparam logic [3:0] S_RND  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]       st_r;
  logic [15:0]      fidx_r;
  logic [SSE_W-1:0] sse_r [3];
  logic [N_W-1:0]   n_r;
  logic [15:0]      pksq_r;
  logic [X_W-1:0]   num_r, xs_r;
  logic [E_W-1:0]   e_r;
  logic [31:0]      m_r;
  logic [63:0]      prod_r;
  logic [LOG_FRAC-1:0] frac_r;
  logic [4:0]       bit_r;
  logic [1:0]       op_r, k_r;
  logic [L_W-1:0]   ln_r;
  logic [L_W-1:0]   ls_r [3];
  logic             neg_r;
  logic [L_W-1:0]   mag_r;
  logic [P_W-1:0]   pp_r;
  logic [15:0]      psnr_r [3];
  out_item_t        out_r;
  logic             out_valid_r;

  logic [32:0]         mp;
  logic [LOG_FRAC-1:0] frac_nxt;
  logic [P_W:0]        rsum, rq;
  logic [15:0]         psnr_nxt;
  logic [X_W-1:0]      opnd;

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;
  assign q_pop     = (st_r == S_IDLE) && !q_empty;

  assign mp       = prod_r[63:31];
  assign frac_nxt = {frac_r[LOG_FRAC-2:0], mp[32]};

  always_comb begin
    case (op_r)
      2'd0:    opnd = num_r;
      2'd1:    opnd = X_W'(sse_r[0]);
      2'd2:    opnd = X_W'(sse_r[1]);
      default: opnd = X_W'(sse_r[2]);
    endcase
    if (opnd == '0) opnd = X_W'(1);
  end

  // round halves away from zero, restore sign, saturate; a zero sum gives the top value
  always_comb begin
    rsum = {1'b0, pp_r} + ((P_W + 1)'(1) << (SH - 1));
    rq   = rsum >> SH;
    if (neg_r) begin
      if (rq > (P_W + 1)'(32768)) rq = (P_W + 1)'(32768);
      psnr_nxt = 16'((P_W + 1)'(0) - rq);
    end else begin
      if (rq > (P_W + 1)'(32767)) rq = (P_W + 1)'(32767);
      psnr_nxt = rq[15:0];
    end
    if (sse_r[k_r] == '0) psnr_nxt = PSNR_MAX;
  end

  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        fidx_r   <= q_rec[REC_W-1 -: 16];
        sse_r[0] <= q_rec[REC_W-17 -: SSE_W];
        sse_r[1] <= q_rec[REC_W-57 -: SSE_W];
        sse_r[2] <= q_rec[REC_W-97 -: SSE_W];
        n_r      <= q_rec[16 +: N_W];
        pksq_r   <= q_rec[15:0];
      end
      S_NUM: num_r <= X_W'((16 + N_W)'(pksq_r) * (16 + N_W)'(n_r));
      S_LOAD: begin
        xs_r <= opnd;
        e_r  <= E_W'(X_W - 1);
      end
      S_NORM: begin
        if (xs_r[X_W-1]) begin
          m_r    <= xs_r[X_W-1 -: 32];
          frac_r <= '0;
          bit_r  <= '0;
        end else begin
          xs_r <= {xs_r[X_W-2:0], 1'b0};
          e_r  <= e_r - E_W'(1);
        end
      end
      S_SQ: prod_r <= 64'(m_r) * 64'(m_r);
      S_DEC: begin
        m_r    <= mp[32] ? mp[32:1] : mp[31:0];
        frac_r <= frac_nxt;
        bit_r  <= bit_r + 5'd1;
        if (bit_r == 5'(LOG_FRAC - 1)) begin
          if (op_r == 2'd0) ln_r <= {e_r, frac_nxt};
          else ls_r[op_r - 2'd1] <= {e_r, frac_nxt};
        end
      end
      S_DIFF: begin
        neg_r <= ls_r[k_r] > ln_r;
        mag_r <= (ls_r[k_r] > ln_r) ? (ls_r[k_r] - ln_r) : (ln_r - ls_r[k_r]);
      end
      S_PMUL: pp_r <= P_W'(mag_r) * P_W'(DB_PER_OCTAVE);
      S_RND:  psnr_r[k_r] <= psnr_nxt;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      op_r        <= 2'd0;
      k_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      // load a finished result, or drop the one just taken
      if (st_r == S_OUT && (!out_valid_r || out_pop)) out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
      case (st_r)
        S_IDLE: if (!q_empty) st_r <= S_NUM;
        S_NUM: begin
          op_r <= 2'd0;
          st_r <= S_LOAD;
        end
        S_LOAD: st_r <= S_NORM;
        S_NORM: if (xs_r[X_W-1]) st_r <= S_SQ;
        S_SQ:   st_r <= S_DEC;
        S_DEC: begin
          if (bit_r == 5'(LOG_FRAC - 1)) begin
            op_r <= op_r + 2'd1;
            if (op_r == 2'd3) begin
              k_r  <= 2'd0;
              st_r <= S_DIFF;
            end else begin
              st_r <= S_LOAD;
            end
          end else begin
            st_r <= S_SQ;
          end
        end
        S_DIFF: st_r <= S_PMUL;
        S_PMUL: st_r <= S_RND;
        S_RND: begin
          k_r  <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
          st_r <= (k_r == 2'd2) ? S_OUT : S_DIFF;
        end
        S_OUT: if (!out_valid_r || out_pop) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_OUT && (!out_valid_r || out_pop)) begin
      out_r.frame_index     <= fidx_r;
      out_r.sse_c0          <= sse_r[0];
      out_r.sse_c1          <= sse_r[1];
      out_r.sse_c2          <= sse_r[2];
      out_r.psnr_c0         <= psnr_r[0];
      out_r.psnr_c1         <= psnr_r[1];
      out_r.psnr_c2         <= psnr_r[2];
      out_r.zero_error_mask <= {sse_r[2] == '0, sse_r[1] == '0, sse_r[0] == '0};
    end
  end

endmodule

[hdl/frame_psnr_three_component_core.sv]
// Per-frame PSNR of a three-component video stream.
// Input channel (in_push / in_full / in_data): one reference/test pixel pair
// per item; one item is taken every clock while in_full is low. The front
// squares each component difference and adds it to a saturating 40-bit sum.
// When the pixel count reaches frame_width*frame_height (each clamped to
// 1..MAX_DIM) the frame record (sums, frame size, peak squared) goes into
// a two-entry queue. Result channel (out_empty / out_pop / out_data): one
// item per frame with the three sums, a Q7.8 dB PSNR per component and a
// zero-error mask. The back computes four log2 values in turn on one
// shared unit: a normalizing shift, then 24 square-and-compare steps, each
// a square state and a decide state, on one 32x32 multiplier.
// When the receiver stalls, the finished result waits in the output register;
// the back holds the next frame and the queue absorbs up to two more frame
// ends before in_full rises.
// Config (cfg_we / cfg_idx / cfg_wdata) takes effect on the next item;
// write it only while idle. rst_n (synchronous) clears sums, counters,
// queue and output, and loads frame 1920x1080 with peak 200.
module frame_psnr_three_component_core #(
  parameter int MAX_DIM        = 4096,
  parameter int PSNR_FRAC_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fpsnr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [fpsnr_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                            in_push,
  input  fpsnr_pkg::in_item_t             in_data,
  output logic                            in_full,
  output logic                            out_empty,
  input  logic                            out_pop,
  output fpsnr_pkg::out_item_t            out_data
);
  import fpsnr_pkg::*;

  // pixel count per frame needs two dimension widths
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int N_W   = 2 * DIM_W;
  // record: frame index, three sums, frame size, peak squared
  localparam int REC_W = 16 + 3 * SSE_W + N_W + 16;

  logic             q_push, q_full, q_pop, q_empty;
  logic [REC_W-1:0] q_wrec, q_rrec;

  fpsnr_front #(.MAX_DIM(MAX_DIM), .N_W(N_W), .REC_W(REC_W)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .q_push    (q_push),
    .q_rec     (q_wrec),
    .q_full    (q_full)
  );

  // frame ends wait here so pixels keep flowing while the back works
  fpsnr_queue #(.W(REC_W)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wrec),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rrec),
    .empty (q_empty)
  );

  fpsnr_back #(.PSNR_FRAC_BITS(PSNR_FRAC_BITS), .N_W(N_W), .REC_W(REC_W)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rec     (q_rrec),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  // the front never writes a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("frame queue overflow");

  // the back never reads an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_empty))
    else $error("frame queue underflow");

  // a zero-error component reports the top PSNR (checked on component 0)
  a_zero_psnr: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.zero_error_mask[0]) |-> (out_data.psnr_c0 == 16'sd32767))
    else $error("zero-error component without top PSNR");

  // mask bit follows its sum (checked on component 1)
  a_mask_sum: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.zero_error_mask[1] == (out_data.sse_c1 == 40'd0)))
    else $error("zero-error mask disagrees with sum");

endmodule

[tb/sv/frame_psnr_three_component_core_tb.sv]
module frame_psnr_three_component_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fpsnr_pkg::*;

  // Allow margin for the back-end computation, in-flight pixels and a queued
  // frame before touching the registers.
  localparam int SETTLE_CYCLES = 800;
  // Cycles with no item moving on either side before the run is declared hung.
  localparam int HANG_LIMIT    = 20000;
  localparam longint unsigned SSE_SAT = 64'hFF_FFFF_FFFF;
  localparam int PSNR_SHIFT = 24 + 30 - 8;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_push;
  in_item_t             in_data;
  logic                 in_full;
  logic                 out_empty;
  logic                 out_pop;
  out_item_t            out_data;

  frame_psnr_three_component_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  // Shadow copy of the block's registers and frame state.
  logic [12:0]     shadow_width;
  logic [12:0]     shadow_height;
  logic [7:0]      shadow_peak;
  longint unsigned frame_sse [3];
  longint unsigned pixels_taken;
  logic [15:0]     frames_done;

  out_item_t pending_frames[$];
  int        error_count;
  int        idle_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // log2 in Q.24: integer part from the leading one, fraction by repeated
  // squaring of the normalized Q1.31 mantissa.
  function automatic longint unsigned log2_fixed(longint unsigned x);
    longint unsigned mant;
    longint unsigned frac;
    int              msb;
    frac = 0;
    msb  = 0;
    if (x == 0) x = 1;
    while (msb < 63 && (x >> (msb + 1)) != 0) msb++;
    if (msb <= 31) mant = x << (31 - msb);
    else mant = x >> (msb - 31);
    for (int i = 0; i < 24; i++) begin
      mant = (mant * mant) >> 31;
      frac = frac << 1;
      if (mant >= 64'h1_0000_0000) begin
        mant = mant >> 1;
        frac = frac | 1;
      end
    end
    return (longint'(msb) << 24) | frac;
  endfunction

  function automatic logic [15:0] psnr_db(longint unsigned num, longint unsigned sse);
    longint unsigned l_num;
    longint unsigned l_sse;
    longint unsigned diff;
    longint unsigned rounded;
    logic            neg;
    l_num   = log2_fixed(num);
    l_sse   = log2_fixed(sse);
    neg     = l_sse > l_num;
    diff    = neg ? l_sse - l_num : l_num - l_sse;
    rounded = (diff * longint'(DB_PER_OCTAVE) + (64'd1 << (PSNR_SHIFT - 1))) >> PSNR_SHIFT;
    if (neg) begin
      if (rounded > 32768) rounded = 32768;
      return 16'(17'h10000 - rounded);
    end
    if (rounded > 32767) rounded = 32767;
    return 16'(rounded);
  endfunction

  function automatic longint unsigned clamp_dim(logic [12:0] d);
    if (d < 1) return 1;
    if (d > 4096) return 4096;
    return d;
  endfunction

  // Accumulate one pixel pair; queue the frame record when the frame closes.
  task automatic accumulate_pixel(in_item_t px);
    longint unsigned pix_per_frame;
    longint unsigned pk;
    longint unsigned num;
    longint signed   d;
    logic [7:0]      refs [3];
    logic [7:0]      tsts [3];
    out_item_t       rec;
    logic [15:0]     psnr [3];
    refs = '{px.ref_c0, px.ref_c1, px.ref_c2};
    tsts = '{px.test_c0, px.test_c1, px.test_c2};
    pix_per_frame = clamp_dim(shadow_width) * clamp_dim(shadow_height);
    pk  = (shadow_peak == 0) ? 1 : shadow_peak;
    num = pk * pk * pix_per_frame;
    for (int k = 0; k < 3; k++) begin
      d = longint'(refs[k]) - longint'(tsts[k]);
      frame_sse[k] = frame_sse[k] + longint'(d * d);
      if (frame_sse[k] > SSE_SAT) frame_sse[k] = SSE_SAT;
    end
    pixels_taken++;
    if (pixels_taken < pix_per_frame) return;
    rec.frame_index     = frames_done;
    rec.zero_error_mask = '0;
    for (int k = 0; k < 3; k++) begin
      if (frame_sse[k] == 0) begin
        rec.zero_error_mask[k] = 1'b1;
        psnr[k] = PSNR_MAX;
      end else begin
        psnr[k] = psnr_db(num, frame_sse[k]);
      end
    end
    rec.sse_c0  = frame_sse[0][39:0];
    rec.sse_c1  = frame_sse[1][39:0];
    rec.sse_c2  = frame_sse[2][39:0];
    rec.psnr_c0 = psnr[0];
    rec.psnr_c1 = psnr[1];
    rec.psnr_c2 = psnr[2];
    pending_frames.push_back(rec);
    frame_sse    = '{0, 0, 0};
    pixels_taken = 0;
    frames_done++;
  endtask

  // Present one pixel pair and hold it until taken.
  task automatic send_pixel(in_item_t px);
    in_push <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (in_full);
    accumulate_pixel(px);
  endtask

  // Random gap after an item: mostly none or short, now and then long.
  task automatic sender_gap();
    int gap;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: gap = 0;
      5, 6, 7, 8:    gap = $urandom_range(1, 3);
      default:       gap = $urandom_range(10, 60);
    endcase
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic in_item_t make_pixel();
    in_item_t px;
    px = in_item_t'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: begin
        // identical pair: zero error
        px.test_c0 = px.ref_c0;
        px.test_c1 = px.ref_c1;
        px.test_c2 = px.ref_c2;
      end
      1: begin
        // small error, typical of a good encoder
        px.test_c0 = px.ref_c0 ^ 8'($urandom_range(0, 3));
        px.test_c1 = px.ref_c1 ^ 8'($urandom_range(0, 3));
        px.test_c2 = px.ref_c2;
      end
      default: ;
    endcase
    return px;
  endfunction

  // Wait until every expected frame has come out, then let the block settle.
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register, then drop the write enable and idle the port before returning.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  shadow_width  = val;
      REG_FRAME_HEIGHT: shadow_height = val;
      REG_PEAK_VALUE:   shadow_peak   = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_frame(logic [12:0] w, logic [12:0] h, logic [7:0] pk);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_PEAK_VALUE, {5'd0, pk});
  endtask

  // One-pixel frames at the widest peak: field extremes, every bit both ways.
  task automatic test_field_extremes();
    in_item_t px;
    set_frame(13'd1, 13'd1, 8'd255);
    send_pixel('0);
    send_pixel('1);
    send_pixel({8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00});
    send_pixel({8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF});
    send_pixel({8'hAA, 8'h55, 8'h00, 8'h55, 8'hAA, 8'h00});
    send_pixel({8'h80, 8'h01, 8'h7F, 8'h7F, 8'h00, 8'h80});
    px = '1;
    px.test_c1 = 8'hFE;
    send_pixel(px);
    drain();
  endtask

  // Zero peak and out-of-range dimensions: clamp to one pixel, error above
  // the numerator drives PSNR negative.
  task automatic test_clamp_and_negative();
    set_frame(13'd0, 13'd0, 8'd0);
    send_pixel({8'hFF, 8'h00, 8'h10, 8'h00, 8'hFF, 8'h10});
    send_pixel({8'h02, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00});
    drain();
    write_reg(REG_PEAK_VALUE, 13'd1);
    send_pixel({8'h01, 8'h00, 8'hFF, 8'h00, 8'h01, 8'h00});
    drain();
  endtask

  // Oversized dimensions clamp to the top: a long partial frame stays open,
  // then closes on the next pixel under a smaller size.
  task automatic test_largest_frames();
    set_frame(13'h1FFF, 13'h1FFF, 8'd128);
    repeat (300) send_pixel(make_pixel());
    drain();
    set_frame(13'd16, 13'd16, 8'd255);
    send_pixel(make_pixel());
    drain();
  endtask

  // Small random frame sizes; a partial frame carries over each size change.
  task automatic test_random_frames();
    for (int phase = 0; phase < 12; phase++) begin
      set_frame(13'($urandom_range(0, 9)), 13'($urandom_range(0, 9)),
                8'($urandom_range(0, 255)));
      for (int i = 0; i < 100; i++) begin
        send_pixel(make_pixel());
        sender_gap();
        // hold off until the output side is empty once per run
        if (phase == 3 && i == 60) begin
          in_push <= 1'b0;
          while (pending_frames.size() != 0) @(posedge clk);
        end
      end
      drain();
    end
  endtask

  task automatic report(string field, longint unsigned exp_v, longint unsigned act_v);
    error_count++;
    $display("%0t: %s mismatch: expected %0h, actual %0h", $realtime, field, exp_v, act_v);
  endtask

  // Result side: random pop stalls, compare each frame with the oldest expected one.
  int stall_left;
  always @(posedge clk) begin
    out_item_t exp_rec;
    if (!rst_n) begin
      out_pop    <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (pending_frames.size() == 0) begin
          error_count++;
          $display("%0t: unexpected frame result %p", $realtime, out_data);
        end else begin
          exp_rec = pending_frames.pop_front();
          if (out_data.frame_index != exp_rec.frame_index)
            report("frame_index", exp_rec.frame_index, out_data.frame_index);
          if (out_data.sse_c0 != exp_rec.sse_c0) report("sse_c0", exp_rec.sse_c0, out_data.sse_c0);
          if (out_data.sse_c1 != exp_rec.sse_c1) report("sse_c1", exp_rec.sse_c1, out_data.sse_c1);
          if (out_data.sse_c2 != exp_rec.sse_c2) report("sse_c2", exp_rec.sse_c2, out_data.sse_c2);
          if (out_data.psnr_c0 != exp_rec.psnr_c0)
            report("psnr_c0", 16'(exp_rec.psnr_c0), 16'(out_data.psnr_c0));
          if (out_data.psnr_c1 != exp_rec.psnr_c1)
            report("psnr_c1", 16'(exp_rec.psnr_c1), 16'(out_data.psnr_c1));
          if (out_data.psnr_c2 != exp_rec.psnr_c2)
            report("psnr_c2", 16'(exp_rec.psnr_c2), 16'(out_data.psnr_c2));
          if (out_data.zero_error_mask != exp_rec.zero_error_mask)
            report("zero_error_mask", exp_rec.zero_error_mask, out_data.zero_error_mask);
        end
      end
      // advance the stall pattern: mostly ready, short stalls, rare long ones
      if (stall_left > 0) begin
        out_pop    <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        case ($urandom_range(0, 19))
          0:       stall_left <= $urandom_range(50, 400);
          1, 2, 3: stall_left <= $urandom_range(1, 4);
          default: stall_left <= 0;
        endcase
        out_pop <= 1'b1;
      end
    end
  end

  // Hang detection: count cycles in which no item moves on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("frame_psnr_three_component_core_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_wdata     = '0;
    in_push       = 1'b0;
    in_data       = '0;
    out_pop       = 1'b0;
    error_count   = 0;
    idle_cycles   = 0;
    shadow_width  = RST_FRAME_WIDTH;
    shadow_height = RST_FRAME_HEIGHT;
    shadow_peak   = RST_PEAK_VALUE;
    frame_sse     = '{0, 0, 0};
    pixels_taken  = 0;
    frames_done   = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_clamp_and_negative();
    test_random_frames();
    test_largest_frames();

    if (error_count == 0) begin
      $display("frame_psnr_three_component_core_tb: PASS");
    end else begin
      $display("frame_psnr_three_component_core_tb: FAIL");
    end
    $finish;
  end

endmodule
